>>> design/tkd_pkg.sv
// shared types, byte codes and plain key mapping for the terminal key decoder
package tkd_pkg;

  localparam logic [7:0] BYTE_IAC = 8'd255;
  localparam logic [7:0] BYTE_SB  = 8'd250;
  localparam logic [7:0] BYTE_SE  = 8'd240;
  localparam logic [7:0] BYTE_ESC = 8'h1b;
  localparam logic [7:0] BYTE_DEL = 8'h7f;
  localparam logic [7:0] BYTE_BS  = 8'h08;
  localparam logic [7:0] BYTE_TAB = 8'h09;
  localparam logic [7:0] BYTE_LF  = 8'h0a;
  localparam logic [7:0] BYTE_CR  = 8'h0d;
  localparam logic [7:0] PRINT_LO = 8'd32;

  localparam logic [7:0] RESET_WIDTH  = 8'd80;
  localparam logic [7:0] RESET_HEIGHT = 8'd25;

  typedef enum logic [4:0] {
    ACT_NONE        = 5'd0,
    ACT_LINE_START  = 5'd1,
    ACT_BACK        = 5'd2,
    ACT_ERASE_LINE  = 5'd3,
    ACT_DELETE      = 5'd4,
    ACT_LINE_END    = 5'd5,
    ACT_FORWARD     = 5'd6,
    ACT_BACKSPACE   = 5'd7,
    ACT_KILL_END    = 5'd8,
    ACT_BS_WORD     = 5'd9,
    ACT_HIST_PREV   = 5'd10,
    ACT_HIST_NEXT   = 5'd11,
    ACT_WORD_BACK   = 5'd12,
    ACT_WORD_FWD    = 5'd13,
    ACT_DELETE_WORD = 5'd14,
    ACT_COMPLETE    = 5'd15,
    ACT_HELP        = 5'd16,
    ACT_ENTER       = 5'd17,
    ACT_INSERT      = 5'd18
  } action_t;

  typedef enum logic [1:0] {
    ESC_IDLE    = 2'd0,
    ESC_SEEN    = 2'd1,
    ESC_BRACKET = 2'd2
  } esc_phase_t;

  // action for a byte outside any escape or telnet sequence
  function automatic action_t plain_action(input logic [7:0] b, input logic nl_enter);
    action_t a;
    a = ACT_NONE;
    case (b)
      8'h01:    a = ACT_LINE_START;
      8'h02:    a = ACT_BACK;
      8'h03:    a = ACT_ERASE_LINE;
      8'h04:    a = ACT_DELETE;
      8'h05:    a = ACT_LINE_END;
      8'h06:    a = ACT_FORWARD;
      BYTE_BS:  a = ACT_BACKSPACE;
      BYTE_DEL: a = ACT_BACKSPACE;
      8'h0b:    a = ACT_KILL_END;
      8'h15:    a = ACT_ERASE_LINE;
      8'h17:    a = ACT_BS_WORD;
      BYTE_TAB: a = ACT_COMPLETE;
      8'h3f:    a = ACT_HELP;
      BYTE_CR:  a = ACT_ENTER;
      BYTE_LF:  a = nl_enter ? ACT_ENTER : ACT_NONE;
      default: begin
        if (b >= PRINT_LO && b < BYTE_DEL) a = ACT_INSERT;
        else a = ACT_NONE;
      end
    endcase
    return a;
  endfunction

endpackage

>>> design/tkd_telnet.sv
// telnet command tracking and window size capture
module tkd_telnet #(
  parameter int SUB_DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] data_byte,
  output logic       consumed,
  output logic [7:0] width_next,
  output logic [7:0] height_next
);

  localparam int CW = $clog2(SUB_DEPTH + 1);

  logic          command_armed;
  logic          in_subnegotiation;
  logic [CW-1:0] sub_count;
  logic [7:0]    sub_byte2;
  logic [7:0]    sub_byte4;
  logic [7:0]    width_reg;
  logic [7:0]    height_reg;
  logic          size_latch;

  assign consumed = (data_byte == tkd_pkg::BYTE_IAC) || command_armed || in_subnegotiation;

  assign size_latch = (data_byte != tkd_pkg::BYTE_IAC) && command_armed &&
                      (data_byte == tkd_pkg::BYTE_SE) && (sub_count >= CW'(5));

  // reported size is the one after this transfer
  assign width_next  = size_latch ? sub_byte2 : width_reg;
  assign height_next = size_latch ? sub_byte4 : height_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      command_armed     <= 1'b0;
      in_subnegotiation <= 1'b0;
      sub_count         <= '0;
      width_reg         <= tkd_pkg::RESET_WIDTH;
      height_reg        <= tkd_pkg::RESET_HEIGHT;
    end else if (accept) begin
      width_reg  <= width_next;
      height_reg <= height_next;
      if (data_byte == tkd_pkg::BYTE_IAC) begin
        command_armed <= 1'b1;
      end else if (command_armed) begin
        if (data_byte == tkd_pkg::BYTE_SB) begin
          in_subnegotiation <= 1'b1;
          sub_count         <= '0;
          command_armed     <= 1'b0;
        end else if (data_byte == tkd_pkg::BYTE_SE) begin
          in_subnegotiation <= 1'b0;
          // a short subnegotiation keeps command mode armed
          if (sub_count >= CW'(5)) command_armed <= 1'b0;
        end else begin
          command_armed <= 1'b0;
        end
      end else if (in_subnegotiation) begin
        if (sub_count < CW'(SUB_DEPTH)) sub_count <= sub_count + CW'(1);
      end
    end
  end

  // only bytes 2 and 4 of the capture are ever used
  always_ff @(posedge clk) begin
    if (accept && !command_armed && in_subnegotiation &&
        data_byte != tkd_pkg::BYTE_IAC) begin
      if (sub_count == CW'(2)) sub_byte2 <= data_byte;
      if (sub_count == CW'(4)) sub_byte4 <= data_byte;
    end
  end

endmodule

>>> design/tkd_keymap.sv
// escape sequence tracking and key to action mapping
module tkd_keymap (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic              consumed,
  input  logic [7:0]        data_byte,
  input  logic              newline_is_enter,
  output tkd_pkg::action_t  action
);

  tkd_pkg::esc_phase_t phase;
  tkd_pkg::esc_phase_t phase_next;
  tkd_pkg::action_t    key_action;

  always_comb begin
    phase_next = tkd_pkg::ESC_IDLE;
    key_action = tkd_pkg::ACT_NONE;
    case (phase)
      tkd_pkg::ESC_BRACKET: begin
        case (data_byte)
          8'h41:   key_action = tkd_pkg::ACT_HIST_PREV;
          8'h42:   key_action = tkd_pkg::ACT_HIST_NEXT;
          8'h43:   key_action = tkd_pkg::ACT_FORWARD;
          8'h44:   key_action = tkd_pkg::ACT_BACK;
          default: key_action = tkd_pkg::ACT_NONE;
        endcase
      end
      tkd_pkg::ESC_SEEN: begin
        case (data_byte)
          8'h5b:             phase_next = tkd_pkg::ESC_BRACKET;
          8'h62:             key_action = tkd_pkg::ACT_WORD_BACK;
          8'h66:             key_action = tkd_pkg::ACT_WORD_FWD;
          8'h64:             key_action = tkd_pkg::ACT_DELETE_WORD;
          tkd_pkg::BYTE_BS:  key_action = tkd_pkg::ACT_BS_WORD;
          tkd_pkg::BYTE_DEL: key_action = tkd_pkg::ACT_BS_WORD;
          default:           key_action = tkd_pkg::ACT_NONE;
        endcase
      end
      default: begin
        if (data_byte == tkd_pkg::BYTE_ESC) phase_next = tkd_pkg::ESC_SEEN;
        else key_action = tkd_pkg::plain_action(data_byte, newline_is_enter);
      end
    endcase
  end

  assign action = consumed ? tkd_pkg::ACT_NONE : key_action;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= tkd_pkg::ESC_IDLE;
    end else if (accept && !consumed) begin
      phase <= phase_next;
    end
  end

endmodule

>>> design/terminal_key_decoder.sv
// terminal key decoder top level: telnet and key decode feeding a result register
// result: registered, on m_tdata in the cycle after the input transfer
// throughput: one byte per cycle while m_tready is high; the single result register frees as it is taken
// s_tready is high whenever the result register is empty or being read
// reset: synchronous rst clears command, capture and escape state, size to 80 x 25
module terminal_key_decoder #(
  parameter int SUB_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tuser,   // [0] newline_is_enter
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata    // [4:0] action, [12:5] insert_char,
                                 // [20:13] term_width, [28:21] term_height
);

  logic             accept;
  logic             consumed;
  logic [7:0]       width_next;
  logic [7:0]       height_next;
  tkd_pkg::action_t action;

  logic [4:0]       action_q;
  logic [7:0]       insert_q;
  logic [7:0]       width_q;
  logic [7:0]       height_q;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  tkd_telnet #(
    .SUB_DEPTH (SUB_DEPTH)
  ) u_telnet (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .data_byte   (s_tdata),
    .consumed    (consumed),
    .width_next  (width_next),
    .height_next (height_next)
  );

  tkd_keymap u_keymap (
    .clk              (clk),
    .rst              (rst),
    .accept           (accept),
    .consumed         (consumed),
    .data_byte        (s_tdata),
    .newline_is_enter (s_tuser),
    .action           (action)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      action_q <= action;
      insert_q <= (action == tkd_pkg::ACT_INSERT) ? s_tdata : 8'd0;
      width_q  <= width_next;
      height_q <= height_next;
    end
  end

  assign m_tdata = {3'b000, height_q, width_q, insert_q, action_q};

endmodule
